// ===== sv/cse_pkg.sv =====
// Shared types and constants for the C string literal escaper.
package cse_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [6:0] WRAP_RESET = 7'd70;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DASH   = 8'h2D;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRIP_COMMENTS = 2'd0,
        CFG_STRIP_CONTENT  = 2'd1,
        CFG_WRAP_COLUMN    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic       strip_comments;
        logic       strip_content;
        logic [6:0] wrap_column;
    } cse_cfg_t;

    // One queued job: a byte that was looked at (emit or break check only),
    // or the end marker with the kept count.
    typedef struct packed {
        logic        is_end;
        logic        emit;
        logic [7:0]  data;
        logic [31:0] count;
    } cse_op_t;

    typedef enum logic [1:0] {
        BK_START,
        BK_BRK,
        BK_ESC
    } back_state_t;

endpackage

// ===== sv/c_string_literal_escaper.sv =====
// Top level: C string literal escaper with configuration registers.
// A byte is looked at once three more bytes (or the last beat) are in; its
//   first character then passes the queue and the output register. Throughput,
//   unless stalled: one output char per cycle; an input beat per cycle while
//   each byte expands to one char, fewer as escapes and line breaks add chars.
// The last beat flushes up to four held bytes, one per cycle, then the end beat.
// Reset (rst_n low, asynchronous) clears all stream state and loads the register
//   defaults: stripping off, wrap column 70. No clearing pass is needed.
module c_string_literal_escaper (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cse_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // data_byte
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [39:0]                     m_tdata,   // out_char, kept_count
    output logic                            m_tuser,   // char_valid
    output logic                            m_tlast
);

    cse_pkg::cse_cfg_t cfg_reg, cfg_next;
    logic              q_push, q_full, q_pop, q_valid;
    cse_pkg::cse_op_t  q_in, q_head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                cse_pkg::CFG_STRIP_COMMENTS: cfg_next.strip_comments = cfg_data[0];
                cse_pkg::CFG_STRIP_CONTENT:  cfg_next.strip_content  = cfg_data[0];
                cse_pkg::CFG_WRAP_COLUMN:    cfg_next.wrap_column    = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '{strip_comments: 1'b0, strip_content: 1'b0,
                         wrap_column: cse_pkg::WRAP_RESET};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_op     (q_in),
        .q_full   (q_full)
    );

    cse_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (q_head)
    );

    cse_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_op     (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sv/cse_front.sv =====
// Front end: lookahead window, comment and content stripping, kept count.
module cse_front (
    input  logic              clk,
    input  logic              rst_n,
    input  cse_pkg::cse_cfg_t cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,  // data_byte
    input  logic              s_tlast,
    output logic              q_push,
    output cse_pkg::cse_op_t  q_op,
    input  logic              q_full
);

    logic [7:0]                      win_reg  [4];
    logic [7:0]                      win_next [4];
    logic [2:0]                      fill_reg, fill_next;
    logic                            flush_reg, flush_next;
    logic [1:0]                      skip_reg, skip_next;
    logic                            incom_reg, incom_next;
    logic                            incont_reg, incont_next;
    logic [cse_pkg::COUNT_WIDTH-1:0] kept_reg, kept_next;

    logic                            acc;
    logic [7:0]                      b3;
    logic [2:0]                      avail;
    logic                            open_mk, close_mk, is_sp;
    logic                            h_push, h_emit, h_keep;
    logic [1:0]                      h_skip;
    logic                            h_incom, h_incont;
    logic [cse_pkg::COUNT_WIDTH-1:0] h_kept;
    logic [31:0]                     kept_out;

    generate
        if (cse_pkg::COUNT_WIDTH > 32) begin : g_sat
            assign kept_out = (|kept_reg[cse_pkg::COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF
                                                                     : kept_reg[31:0];
        end else begin : g_ext
            assign kept_out = 32'(kept_reg);
        end
    endgenerate

    assign s_tready = !flush_reg && !q_full;
    assign acc      = s_tvalid && s_tready;
    assign b3       = flush_reg ? win_reg[3] : s_tdata;
    assign avail    = flush_reg ? fill_reg : 3'd4;

    always_comb
    begin
        open_mk  = (avail >= 3'd4) && win_reg[0] == cse_pkg::CH_LT
                   && win_reg[1] == cse_pkg::CH_BANG && win_reg[2] == cse_pkg::CH_DASH
                   && b3 == cse_pkg::CH_DASH;
        close_mk = (avail >= 3'd3) && win_reg[0] == cse_pkg::CH_DASH
                   && win_reg[1] == cse_pkg::CH_DASH && win_reg[2] == cse_pkg::CH_GT;
        is_sp    = win_reg[0] == cse_pkg::CH_SPACE
                   || (win_reg[0] >= cse_pkg::CH_TAB && win_reg[0] <= cse_pkg::CH_CR);

        h_push   = 1'b0;
        h_emit   = 1'b0;
        h_keep   = 1'b0;
        h_skip   = skip_reg;
        h_incom  = incom_reg;
        h_incont = incont_reg;
        h_kept   = kept_reg;
        if (skip_reg != 2'd0) begin
            h_skip = skip_reg - 2'd1;
        end else begin
            h_push = 1'b1;
            if (cfg.strip_comments && open_mk) begin
                h_incom = 1'b1;
                h_skip  = 2'd3;
            end else if (cfg.strip_comments && incom_reg) begin
                if (close_mk) begin
                    h_incom = 1'b0;
                    h_skip  = 2'd2;
                end
            end else begin
                h_keep = 1'b1;
                if (cfg.strip_content) begin
                    if (!incont_reg && win_reg[0] == cse_pkg::CH_GT)
                        h_incont = 1'b1;
                    else if (incont_reg && win_reg[0] == cse_pkg::CH_LT)
                        h_incont = 1'b0;
                    else if (incont_reg && !is_sp)
                        h_incont = 1'b0;
                    else if (incont_reg)
                        h_keep = 1'b0;
                end
                if (h_keep) begin
                    h_emit = 1'b1;
                    h_kept = (&kept_reg) ? kept_reg
                                         : kept_reg + cse_pkg::COUNT_WIDTH'(1);
                end
            end
        end

        win_next    = win_reg;
        fill_next   = fill_reg;
        flush_next  = flush_reg;
        skip_next   = skip_reg;
        incom_next  = incom_reg;
        incont_next = incont_reg;
        kept_next   = kept_reg;
        q_push      = 1'b0;
        q_op        = '{is_end: 1'b0, emit: h_emit, data: win_reg[0], count: 32'd0};

        if (acc) begin
            if (!s_tlast && fill_reg == 3'd3) begin
                skip_next   = h_skip;
                incom_next  = h_incom;
                incont_next = h_incont;
                kept_next   = h_kept;
                q_push      = h_push;
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = s_tdata;
            end else begin
                win_next[fill_reg[1:0]] = s_tdata;
                fill_next               = fill_reg + 3'd1;
                flush_next              = s_tlast;
            end
        end else if (flush_reg) begin
            if (fill_reg != 3'd0) begin
                if (!h_push || !q_full) begin
                    skip_next   = h_skip;
                    incom_next  = h_incom;
                    incont_next = h_incont;
                    kept_next   = h_kept;
                    q_push      = h_push;
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    win_next[2] = win_reg[3];
                    fill_next   = fill_reg - 3'd1;
                end
            end else if (!q_full) begin
                q_push      = 1'b1;
                q_op        = '{is_end: 1'b1, emit: 1'b0, data: 8'd0, count: kept_out};
                flush_next  = 1'b0;
                skip_next   = 2'd0;
                incom_next  = 1'b0;
                incont_next = 1'b1;
                kept_next   = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg   <= 3'd0;
            flush_reg  <= 1'b0;
            skip_reg   <= 2'd0;
            incom_reg  <= 1'b0;
            incont_reg <= 1'b1;
            kept_reg   <= '0;
        end else begin
            fill_reg   <= fill_next;
            flush_reg  <= flush_next;
            skip_reg   <= skip_next;
            incom_reg  <= incom_next;
            incont_reg <= incont_next;
            kept_reg   <= kept_next;
        end
    end

endmodule

// ===== sv/cse_fifo.sv =====
// Short job queue between the front end and the character generator.
module cse_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cse_pkg::cse_op_t push_op,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output cse_pkg::cse_op_t head_op
);

    cse_pkg::cse_op_t                mem_reg [cse_pkg::QUEUE_DEPTH];
    logic [cse_pkg::QPTR_W-1:0]      wr_reg, rd_reg;
    logic [cse_pkg::QCNT_W-1:0]      cnt_reg;
    logic                            do_push, do_pop;

    assign full       = cnt_reg == cse_pkg::QCNT_W'(cse_pkg::QUEUE_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_op    = mem_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push)
                wr_reg <= wr_reg + cse_pkg::QPTR_W'(1);
            if (do_pop)
                rd_reg <= rd_reg + cse_pkg::QPTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + cse_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - cse_pkg::QCNT_W'(1);
        end
    end

endmodule

// ===== sv/cse_back.sv =====
// Back end: line breaks, escape sequences and the registered output beat.
module cse_back (
    input  logic              clk,
    input  logic              rst_n,
    input  cse_pkg::cse_cfg_t cfg,
    input  logic              q_valid,
    input  cse_pkg::cse_op_t  q_op,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,  // out_char[7:0], kept_count[39:8]
    output logic              m_tuser,  // char_valid
    output logic              m_tlast
);

    function automatic logic is_pair(input logic [7:0] c);
        return c == cse_pkg::CH_DQUOTE || c == cse_pkg::CH_APOS || c == cse_pkg::CH_BSLASH
            || c == cse_pkg::CH_LF || c == cse_pkg::CH_CR || c == cse_pkg::CH_TAB;
    endfunction

    function automatic logic is_print(input logic [7:0] c);
        return c >= 8'h20 && c <= 8'h7E;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= cse_pkg::CH_ZERO && c <= cse_pkg::CH_NINE;
    endfunction

    function automatic logic [2:0] esc_len(input logic [7:0] c, input logic oct);
        logic [2:0] r;
        if (is_pair(c))
            r = 3'd2;
        else if (is_print(c))
            r = (oct && is_digit(c)) ? 3'd3 : 3'd1;
        else
            r = 3'd4;
        return r;
    endfunction

    function automatic logic [7:0] esc_char(input logic [7:0] c, input logic oct,
                                           input logic [2:0] idx);
        logic [7:0] r;
        r = c;
        if (is_pair(c)) begin
            if (idx == 3'd0) begin
                r = cse_pkg::CH_BSLASH;
            end else begin
                case (c)
                    cse_pkg::CH_LF:  r = cse_pkg::CH_LOW_N;
                    cse_pkg::CH_CR:  r = cse_pkg::CH_LOW_R;
                    cse_pkg::CH_TAB: r = cse_pkg::CH_LOW_T;
                    default:         r = c;
                endcase
            end
        end else if (is_print(c)) begin
            if (oct && is_digit(c) && idx != 3'd2)
                r = cse_pkg::CH_DQUOTE;
        end else begin
            case (idx)
                3'd0:    r = cse_pkg::CH_BSLASH;
                3'd1:    r = cse_pkg::CH_ZERO + {6'd0, c[7:6]};
                3'd2:    r = cse_pkg::CH_ZERO + {5'd0, c[5:3]};
                default: r = cse_pkg::CH_ZERO + {5'd0, c[2:0]};
            endcase
        end
        return r;
    endfunction

    function automatic logic [7:0] brk_char(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd1:    r = cse_pkg::CH_LF;
            3'd2:    r = cse_pkg::CH_SPACE;
            3'd3:    r = cse_pkg::CH_SPACE;
            default: r = cse_pkg::CH_DQUOTE;
        endcase
        return r;
    endfunction

    cse_pkg::back_state_t state_reg, state_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [7:0]           col_reg, col_next;
    logic                 oct_reg, oct_next;
    logic                 ovalid_reg, ovalid_next;
    logic [7:0]           ochar_reg, ochar_next;
    logic                 ouser_reg, ouser_next;
    logic                 olast_reg, olast_next;
    logic [31:0]          ocount_reg, ocount_next;

    logic                 adv;
    logic [2:0]           eidx;
    logic [2:0]           elen;
    logic [7:0]           echar;
    logic                 eoct;

    assign adv   = q_valid && (!ovalid_reg || m_tready);
    assign eidx  = (state_reg == cse_pkg::BK_ESC) ? cnt_reg : 3'd0;
    assign elen  = esc_len(q_op.data, oct_reg);
    assign echar = esc_char(q_op.data, oct_reg, eidx);
    assign eoct  = !is_pair(q_op.data) && !is_print(q_op.data);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        col_next    = col_reg;
        oct_next    = oct_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ochar_next  = ochar_reg;
        ouser_next  = ouser_reg;
        olast_next  = olast_reg;
        ocount_next = ocount_reg;
        q_pop       = 1'b0;

        if (adv) begin
            case (state_reg)
                cse_pkg::BK_START:
                begin
                    if (q_op.is_end) begin
                        ovalid_next = 1'b1;
                        ochar_next  = 8'd0;
                        ouser_next  = 1'b0;
                        olast_next  = 1'b1;
                        ocount_next = q_op.count;
                        q_pop       = 1'b1;
                        col_next    = 8'd0;
                        oct_next    = 1'b0;
                    end else if (col_reg > {1'b0, cfg.wrap_column}) begin
                        ovalid_next = 1'b1;
                        ochar_next  = brk_char(3'd0);
                        ouser_next  = 1'b1;
                        olast_next  = 1'b0;
                        ocount_next = 32'd0;
                        col_next    = 8'd0;
                        cnt_next    = 3'd1;
                        state_next  = cse_pkg::BK_BRK;
                    end else if (q_op.emit) begin
                        ovalid_next = 1'b1;
                        ochar_next  = echar;
                        ouser_next  = 1'b1;
                        olast_next  = 1'b0;
                        ocount_next = 32'd0;
                        col_next    = col_reg + 8'd1;
                        if (elen == 3'd1) begin
                            q_pop    = 1'b1;
                            oct_next = eoct;
                        end else begin
                            cnt_next   = 3'd1;
                            state_next = cse_pkg::BK_ESC;
                        end
                    end else begin
                        q_pop = 1'b1;
                    end
                end
                cse_pkg::BK_BRK:
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = brk_char(cnt_reg);
                    ouser_next  = 1'b1;
                    olast_next  = 1'b0;
                    ocount_next = 32'd0;
                    if (cnt_reg == 3'd4) begin
                        cnt_next = 3'd0;
                        if (q_op.emit) begin
                            state_next = cse_pkg::BK_ESC;
                        end else begin
                            q_pop      = 1'b1;
                            state_next = cse_pkg::BK_START;
                        end
                    end else begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                cse_pkg::BK_ESC:
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = echar;
                    ouser_next  = 1'b1;
                    olast_next  = 1'b0;
                    ocount_next = 32'd0;
                    col_next    = col_reg + 8'd1;
                    if (cnt_reg == elen - 3'd1) begin
                        q_pop      = 1'b1;
                        oct_next   = eoct;
                        cnt_next   = 3'd0;
                        state_next = cse_pkg::BK_START;
                    end else begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                default:
                begin
                    state_next = cse_pkg::BK_START;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        ochar_reg  <= ochar_next;
        ouser_reg  <= ouser_next;
        olast_reg  <= olast_next;
        ocount_reg <= ocount_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= cse_pkg::BK_START;
            cnt_reg    <= 3'd0;
            col_reg    <= 8'd0;
            oct_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            col_reg    <= col_next;
            oct_reg    <= oct_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {ocount_reg, ochar_reg};
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

endmodule

// ===== sv/cse_checker.sv =====
// Port-level checks for the C string literal escaper, bound to the top level.
module cse_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [39:0]                     m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output beat changed while stalled");

    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast != m_tuser))
        else $error("beat is neither a plain character nor a bare end beat");

    a_count_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[39:8] == 32'd0)
        else $error("kept count nonzero on a character beat");

    a_char_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[7:0] == 8'd0)
        else $error("end beat carries a character");

endmodule

bind c_string_literal_escaper cse_checker u_cse_checker (.*);

// ===== verif/tb.sv =====
// Testbench for c_string_literal_escaper: escaping, comment and whitespace stripping, wrap.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cse_pkg::*;

    localparam int RAND_ITEMS = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT = 50000;
    localparam logic [4:0][7:0] BREAK_SEQ = {CH_DQUOTE, CH_SPACE, CH_SPACE, CH_LF, CH_DQUOTE};

    typedef struct packed {
        logic [31:0] count;
        logic [7:0]  ch;
        logic        valid;
        logic        eos;
    } lit_item_t;

    class literal_scoreboard;
        logic            strip_cmt;
        logic            strip_ws;
        logic [6:0]      wrap_col;
        logic [2:0][7:0] held;
        int              held_cnt;
        int              skip_left;
        logic            in_cmt;
        logic            in_ws;
        logic [7:0]      col;
        logic            oct_pend;
        logic [31:0]     kept;
        lit_item_t       chars_q[$];
        int              errors;
        int              bytes_in;
        int              sets_done;
        int              chars_out;

        function new();
            strip_cmt = 1'b0;
            strip_ws  = 1'b0;
            wrap_col  = WRAP_RESET;
            errors    = 0;
            bytes_in  = 0;
            sets_done = 0;
            chars_out = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            held      = '0;
            held_cnt  = 0;
            skip_left = 0;
            in_cmt    = 1'b0;
            in_ws     = 1'b1;
            col       = '0;
            oct_pend  = 1'b0;
            kept      = '0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [6:0] val);
            case (idx)
                CFG_STRIP_COMMENTS: strip_cmt = val[0];
                CFG_STRIP_CONTENT:  strip_ws  = val[0];
                CFG_WRAP_COLUMN:    wrap_col  = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return chars_q.size();
        endfunction

        function void push_item(logic [7:0] ch, logic v, logic e, logic [31:0] cnt);
            lit_item_t it;
            it.ch    = ch;
            it.valid = v;
            it.eos   = e;
            it.count = cnt;
            chars_q.push_back(it);
        endfunction

        function void push_char(logic [7:0] ch);
            push_item(ch, 1'b1, 1'b0, '0);
            col = col + 8'd1;
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        // Process the oldest byte of the window; avail = bytes of the window that are known.
        function void handle(logic [3:0][7:0] w, int avail);
            logic [7:0] c;
            c = w[0];
            if (skip_left > 0) begin
                skip_left--;
                return;
            end
            if (col > {1'b0, wrap_col}) begin
                for (int k = 0; k < 5; k++)
                    push_item(BREAK_SEQ[k], 1'b1, 1'b0, '0);
                col = '0;
            end
            if (strip_cmt) begin
                if (avail >= 4 && w[0] == CH_LT && w[1] == CH_BANG && w[2] == CH_DASH
                    && w[3] == CH_DASH) begin
                    in_cmt    = 1'b1;
                    skip_left = 3;
                    return;
                end
                else if (in_cmt) begin
                    if (avail >= 3 && w[0] == CH_DASH && w[1] == CH_DASH && w[2] == CH_GT) begin
                        in_cmt    = 1'b0;
                        skip_left = 2;
                    end
                    return;
                end
            end
            if (strip_ws) begin
                if (!in_ws && c == CH_GT)
                    in_ws = 1'b1;
                else if (in_ws && c == CH_LT)
                    in_ws = 1'b0;
                else if (in_ws && !is_space(c))
                    in_ws = 1'b0;
                else if (in_ws)
                    return;
            end
            if (c == CH_DQUOTE || c == CH_APOS || c == CH_BSLASH) begin
                push_char(CH_BSLASH);
                push_char(c);
                oct_pend = 1'b0;
            end
            else if (c == CH_LF || c == CH_CR || c == CH_TAB) begin
                push_char(CH_BSLASH);
                push_char(c == CH_LF ? CH_LOW_N : (c == CH_CR ? CH_LOW_R : CH_LOW_T));
                oct_pend = 1'b0;
            end
            else if (c >= CH_SPACE && c <= 8'h7E) begin
                if (oct_pend && c >= CH_ZERO && c <= CH_NINE) begin
                    push_char(CH_DQUOTE);
                    push_char(CH_DQUOTE);
                end
                push_char(c);
                oct_pend = 1'b0;
            end
            else begin
                push_char(CH_BSLASH);
                push_char(CH_ZERO + {6'b0, c[7:6]});
                push_char(CH_ZERO + {5'b0, c[5:3]});
                push_char(CH_ZERO + {5'b0, c[2:0]});
                oct_pend = 1'b1;
            end
            if (kept != 32'hFFFF_FFFF)
                kept = kept + 32'd1;
        endfunction

        function void note_input(logic [7:0] b, logic last);
            logic [3:0][7:0] w;
            int n;
            w = '0;
            n = held_cnt;
            for (int i = 0; i < n; i++)
                w[i] = held[i];
            w[n] = b;
            n++;
            bytes_in++;
            if (!last) begin
                if (n == 4) begin
                    handle(w, 4);
                    for (int i = 0; i < 3; i++)
                        held[i] = w[i + 1];
                    held_cnt = 3;
                end
                else begin
                    for (int i = 0; i < n; i++)
                        held[i] = w[i];
                    held_cnt = n;
                end
            end
            else begin
                for (int i = 0; i < n; i++)
                    handle(w >> (8 * i), n - i);
                push_item('0, 1'b0, 1'b1, kept);
                clear_stream();
            end
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [39:0] tdata, logic tuser, logic tlast);
            lit_item_t want;
            if (chars_q.size() == 0) begin
                report($sformatf("unexpected beat char=%02h user=%b last=%b count=%0d",
                                 tdata[7:0], tuser, tlast, tdata[39:8]));
                return;
            end
            want = chars_q.pop_front();
            chars_out++;
            if (tlast === 1'b1)
                sets_done++;
            if (tdata[7:0] !== want.ch)
                report($sformatf("out_char %02h, want %02h", tdata[7:0], want.ch));
            if (tuser !== want.valid)
                report($sformatf("char_valid %b, want %b", tuser, want.valid));
            if (tlast !== want.eos)
                report($sformatf("end_of_stream %b, want %b", tlast, want.eos));
            if (tdata[39:8] !== want.count)
                report($sformatf("kept_count %0d, want %0d", tdata[39:8], want.count));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    literal_scoreboard sb = new();
    bit                calm = 1'b0;
    logic [7:0]        frame_q[$];
    int                rand_items = 0;
    int                phases = 0;

    c_string_literal_escaper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
        m_tready <= calm || ($urandom_range(0, 99) >= 9);
    end

    task automatic put_reg(cfg_index_t idx, logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic write_config(logic strip_cmt, logic strip_ws, logic [6:0] wrap);
        put_reg(CFG_STRIP_COMMENTS, {6'b0, strip_cmt});
        put_reg(CFG_STRIP_CONTENT, {6'b0, strip_ws});
        put_reg(CFG_WRAP_COLUMN, wrap);
        cfg_valid <= 1'b0;
        phases++;
    endtask

    task automatic send_beat(logic [7:0] b, logic last);
        while (!calm && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        sb.note_input(b, last);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(bit with_pause);
        int stop_at;
        stop_at = with_pause ? $urandom_range(0, frame_q.size() - 1) : -1;
        for (int i = 0; i < frame_q.size(); i++) begin
            send_beat(frame_q[i], i == frame_q.size() - 1);
            if (i == stop_at && i != frame_q.size() - 1)
                drain();
        end
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            frame_q.push_back(s[i]);
    endtask

    // Mostly XML-like fragments and escape-heavy bytes, with some raw noise.
    task automatic build_frame(int len);
        int r;
        frame_q.delete();
        while (frame_q.size() < len) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                push_text("<!--");
            else if (r < 20)
                push_text("-->");
            else if (r < 28)
                frame_q.push_back(CH_LT);
            else if (r < 38)
                frame_q.push_back(CH_GT);
            else if (r < 50)
                frame_q.push_back(8'($urandom_range(0, 1) ? CH_SPACE : $urandom_range(9, 13)));
            else if (r < 60)
                frame_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
            else if (r < 70)
                frame_q.push_back(8'($urandom_range(0, 1) ? $urandom_range(0, 31)
                                                         : $urandom_range(127, 255)));
            else if (r < 78)
                case ($urandom_range(0, 2))
                    0: frame_q.push_back(CH_DQUOTE);
                    1: frame_q.push_back(CH_APOS);
                    default: frame_q.push_back(CH_BSLASH);
                endcase
            else if (r < 88)
                frame_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
            else
                frame_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        logic [6:0] wrap;
        int         nframes;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: every escape class, both byte extremes, digit after octal.
        frame_q = {8'h00, 8'hFF, CH_DQUOTE, CH_APOS, CH_BSLASH, CH_LF, CH_CR, CH_TAB,
                   8'h01, 8'h35};
        send_frame(1'b0);
        settle();

        // Nested comment open, close, '>' then whitespace, comment open exactly at the end.
        write_config(1'b1, 1'b1, 7'd1);
        frame_q.delete();
        push_text("<!--<!---->> b<!--");
        send_frame(1'b0);
        settle();

        while (rand_items < RAND_ITEMS) begin
            case (phases)
                2:       wrap = 7'd127;
                3:       wrap = 7'd0;
                4:       wrap = 7'd1;
                default: wrap = 7'($urandom_range(0, 3) == 0 ? $urandom_range(1, 127)
                                                           : $urandom_range(1, 30));
            endcase
            calm = (phases == 2 || phases == 3);
            write_config($urandom_range(0, 1), $urandom_range(0, 1), wrap);
            if (wrap == 7'd127) begin
                frame_q.delete();
                repeat (36) frame_q.push_back(8'($urandom_range(128, 255)));
                rand_items += frame_q.size();
                send_frame(1'b0);
            end
            nframes = $urandom_range(1, 3);
            repeat (nframes) begin
                build_frame($urandom_range(1, 14));
                rand_items += frame_q.size();
                send_frame($urandom_range(0, 3) == 0);
            end
            settle();
        end
        calm = 1'b0;

        for (int k = 0; k < DRAIN_LIMIT && sb.pending() != 0; k++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected characters never arrived", sb.pending()));

        $display("Sent %0d bytes in %0d data sets over %0d register settings;",
                 sb.bytes_in, sb.sets_done, phases);
        $display("checked %0d output beats with %0d mismatches.", sb.chars_out, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
